/* rtl/bfsc_pkg.sv */
`default_nettype none
package bfsc_pkg;

    localparam int CACHE_ENTRIES     = 32;
    localparam int PAGE_BYTES        = 4096;
    localparam int MIN_SEGMENT_BYTES = 1048576;
    localparam int HEADER_BYTES      = 64;

    localparam int IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(CACHE_ENTRIES + 1);
    localparam int BASE_W  = 48;
    localparam int SIZE_W  = 40;
    localparam int TOTAL_W = 42;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RETURN  = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    localparam logic [1:0] CFG_CACHE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MAX_CACHED  = 2'd1;
    localparam logic [1:0] CFG_KEEP_RES    = 2'd2;

    localparam logic [2:0] K_GRANT      = 3'd0;
    localparam logic [2:0] K_GROW       = 3'd1;
    localparam logic [2:0] K_OS_MAP     = 3'd2;
    localparam logic [2:0] K_RELEASE    = 3'd3;
    localparam logic [2:0] K_RET_CACHED = 3'd4;
    localparam logic [2:0] K_FLUSH_DONE = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_PAD, S_ROUND, S_DECIDE, S_SCAN, S_PICK,
        S_SPLIT, S_GRANT, S_GROW, S_OSMAP, S_RET, S_FLUSH
    } t_state;

    typedef struct packed {
        logic take_prev;
        logic take_next;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* rtl/bfsc_cell.sv */
`default_nettype none
module bfsc_cell
    import bfsc_pkg::*;
(
    input  wire                i_clk,
    input  wire t_cell_ctl     i_ctl,
    input  wire [BASE_W-1:0]   i_prev_base,
    input  wire [SIZE_W-1:0]   i_prev_size,
    input  wire [BASE_W-1:0]   i_next_base,
    input  wire [SIZE_W-1:0]   i_next_size,
    input  wire [SIZE_W-1:0]   i_total,
    output logic [BASE_W-1:0]  o_base,
    output logic [SIZE_W-1:0]  o_size,
    output logic [SIZE_W-1:0]  o_dist
);

    logic [BASE_W-1:0] r_base;
    logic [SIZE_W-1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_prev) begin
            r_base <= i_prev_base;
            r_size <= i_prev_size;
        end else if (i_ctl.take_next) begin
            r_base <= i_next_base;
            r_size <= i_next_size;
        end
    end

    assign o_base = r_base;
    assign o_size = r_size;
    assign o_dist = (r_size > i_total) ? (r_size - i_total) : (i_total - r_size);

endmodule
`default_nettype wire

/* rtl/best_fit_segment_cache_top.sv */
// A flush gives one result per cycle whenever the output register can accept it.
// Throughput: one item at a time; the next is accepted once the current item's results
// have all been loaded into the output register (which may still wait to be taken).
// The best-fit scan walks the cell chain one entry per cycle and stops on an exact match.
// Reset (synchronous, active low) empties the list, zeroes the byte total and loads defaults.
`default_nettype none
module best_fit_segment_cache_top
    import bfsc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_idx,
    input  wire [SIZE_W-1:0]   i_cfg_data,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire [1:0]          i_opcode,
    input  wire [SIZE_W-1:0]   i_request_bytes,
    input  wire [BASE_W-1:0]   i_block_base,
    input  wire [SIZE_W-1:0]   i_block_bytes,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [2:0]         o_kind,
    output logic [BASE_W-1:0]  o_out_base,
    output logic [SIZE_W-1:0]  o_out_bytes,
    output logic [SIZE_W-1:0]  o_old_bytes,
    output logic [SIZE_W-1:0]  o_cached_total,
    output logic               o_last
);

    localparam logic [TOTAL_W-1:0] PAGE_MASK = TOTAL_W'(PAGE_BYTES - 1);
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;

    t_state r_state, n_state;
    logic [SIZE_W-1:0]  r_limit, r_max;
    logic               r_keep;
    logic [1:0]         r_op;
    logic [SIZE_W-1:0]  r_req, r_bbytes;
    logic [BASE_W-1:0]  r_bbase;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SIZE_W-1:0]  r_held, n_held;
    logic [IDX_W-1:0]   r_idx, n_idx, r_best, n_best;
    logic [SIZE_W-1:0]  r_bd, n_bd;
    logic [BASE_W-1:0]  r_sel_base, n_sel_base;
    logic [SIZE_W-1:0]  r_sel_size, n_sel_size;

    logic               r_ov, n_ov;
    logic [2:0]         r_kind, n_kind;
    logic [BASE_W-1:0]  r_obase, n_obase;
    logic [SIZE_W-1:0]  r_obytes, n_obytes, r_oold, n_oold, r_ototal, n_ototal;
    logic               r_olast, n_olast;

    logic               can_emit, emit;
    logic               do_push, do_rm;
    logic [IDX_W-1:0]   rm_idx;
    logic [BASE_W-1:0]  push_base;
    logic [SIZE_W-1:0]  push_size;

    logic [BASE_W-1:0]  c_base [CACHE_ENTRIES];
    logic [SIZE_W-1:0]  c_size [CACHE_ENTRIES];
    logic [SIZE_W-1:0]  c_dist [CACHE_ENTRIES];
    t_cell_ctl          c_ctl  [CACHE_ENTRIES];

    logic [TOTAL_W-1:0] padded;
    logic [SIZE_W-1:0]  scan_d;
    logic [BASE_W-1:0]  res_base;
    logic [SIZE_W-1:0]  res_size;
    logic               ret_refuse;

    assign can_emit = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    genvar g;
    generate
        for (g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
            logic [BASE_W-1:0] pb, nb;
            logic [SIZE_W-1:0] ps, ns;
            if (g == 0) begin : g_first
                assign pb = push_base;
                assign ps = push_size;
            end else begin : g_mid
                assign pb = c_base[g-1];
                assign ps = c_size[g-1];
            end
            if (g == CACHE_ENTRIES - 1) begin : g_last
                assign nb = '0;
                assign ns = '0;
            end else begin : g_inner
                assign nb = c_base[g+1];
                assign ns = c_size[g+1];
            end
            assign c_ctl[g].take_prev = do_push;
            assign c_ctl[g].take_next = do_rm && (IDX_W'(g) >= rm_idx);
            bfsc_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (c_ctl[g]),
                .i_prev_base (pb),
                .i_prev_size (ps),
                .i_next_base (nb),
                .i_next_size (ns),
                .i_total     (r_total[SIZE_W-1:0]),
                .o_base      (c_base[g]),
                .o_size      (c_size[g]),
                .o_dist      (c_dist[g])
            );
        end
    endgenerate

    assign padded   = TOTAL_W'(r_req) + TOTAL_W'(HEADER_BYTES);
    assign scan_d   = c_dist[r_idx];
    assign res_base = r_sel_base + BASE_W'(r_total);
    assign res_size = r_sel_size - r_total[SIZE_W-1:0];
    assign ret_refuse = (r_bbytes > r_limit)
                     || ((SIZE_W+1)'(r_bbytes) + (SIZE_W+1)'(r_held) > (SIZE_W+1)'(r_max))
                     || (r_count >= CNT_W'(CACHE_ENTRIES));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_opcode)
                        OP_REQUEST: n_state = S_PAD;
                        OP_RETURN:  n_state = S_RET;
                        OP_FLUSH:   n_state = S_FLUSH;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_PAD:    n_state = S_ROUND;
            S_ROUND:  n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_total <= TOTAL_W'(r_limit) && r_count != '0) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OSMAP;
                end
            end
            S_SCAN: begin
                if (scan_d == '0 || CNT_W'(r_idx) == r_count - 1'b1) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (c_size[r_best] < r_total[SIZE_W-1:0]) begin
                    n_state = S_GROW;
                end else if (c_size[r_best] > r_total[SIZE_W-1:0]) begin
                    n_state = S_SPLIT;
                end else begin
                    n_state = S_GRANT;
                end
            end
            S_SPLIT: begin
                if ((r_keep && res_size <= r_limit) || can_emit) begin
                    n_state = S_GRANT;
                end
            end
            S_GRANT, S_GROW, S_OSMAP, S_RET: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (can_emit && r_count == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_total    = r_total;
        n_count    = r_count;
        n_held     = r_held;
        n_idx      = r_idx;
        n_best     = r_best;
        n_bd       = r_bd;
        n_sel_base = r_sel_base;
        n_sel_size = r_sel_size;
        do_push    = 1'b0;
        do_rm      = 1'b0;
        rm_idx     = '0;
        push_base  = r_bbase;
        push_size  = r_bbytes;
        emit       = 1'b0;
        n_kind     = r_kind;
        n_obase    = '0;
        n_obytes   = '0;
        n_oold     = '0;
        n_ototal   = r_held;
        n_olast    = 1'b1;
        case (r_state)
            S_PAD: begin
                n_total = (padded < TOTAL_W'(MIN_SEGMENT_BYTES)) ?
                          TOTAL_W'(MIN_SEGMENT_BYTES) : padded;
            end
            S_ROUND:  n_total = (r_total + PAGE_MASK) & ~PAGE_MASK;
            S_DECIDE: begin
                n_idx  = '0;
                n_best = '0;
                n_bd   = SIZE_MAX;
            end
            S_SCAN: begin
                if (scan_d < r_bd) begin
                    n_bd   = scan_d;
                    n_best = r_idx;
                end
                n_idx = r_idx + 1'b1;
            end
            S_PICK: begin
                n_sel_base = c_base[r_best];
                n_sel_size = c_size[r_best];
                do_rm      = 1'b1;
                rm_idx     = r_best;
                n_count    = r_count - 1'b1;
                n_held     = r_held - c_size[r_best];
            end
            S_SPLIT: begin
                if (r_keep && res_size <= r_limit) begin
                    do_push   = 1'b1;
                    push_base = res_base;
                    push_size = res_size;
                    n_count   = r_count + 1'b1;
                    n_held    = r_held + res_size;
                end else if (can_emit) begin
                    emit     = 1'b1;
                    n_kind   = K_RELEASE;
                    n_obase  = res_base;
                    n_obytes = res_size;
                    n_olast  = 1'b0;
                end
            end
            S_GRANT: begin
                emit     = can_emit;
                n_kind   = K_GRANT;
                n_obase  = r_sel_base;
                n_obytes = r_total[SIZE_W-1:0];
            end
            S_GROW: begin
                emit     = can_emit;
                n_kind   = K_GROW;
                n_obase  = r_sel_base;
                n_obytes = r_total[SIZE_W-1:0];
                n_oold   = r_sel_size;
            end
            S_OSMAP: begin
                emit     = can_emit;
                n_kind   = K_OS_MAP;
                n_obytes = (r_total > TOTAL_W'(SIZE_MAX)) ? SIZE_MAX : r_total[SIZE_W-1:0];
            end
            S_RET: begin
                emit = can_emit;
                if (ret_refuse) begin
                    n_kind   = K_RELEASE;
                    n_obase  = r_bbase;
                    n_obytes = r_bbytes;
                end else begin
                    n_kind   = K_RET_CACHED;
                    n_ototal = r_held + r_bbytes;
                    if (can_emit) begin
                        do_push = 1'b1;
                        n_count = r_count + 1'b1;
                        n_held  = r_held + r_bbytes;
                    end
                end
            end
            S_FLUSH: begin
                emit = can_emit;
                if (r_count == '0) begin
                    n_kind   = K_FLUSH_DONE;
                    n_ototal = '0;
                    if (can_emit) begin
                        n_held = '0;
                    end
                end else begin
                    n_kind   = K_RELEASE;
                    n_obase  = c_base[0];
                    n_obytes = c_size[0];
                    n_ototal = r_held - c_size[0];
                    n_olast  = 1'b0;
                    if (can_emit) begin
                        do_rm   = 1'b1;
                        n_count = r_count - 1'b1;
                        n_held  = r_held - c_size[0];
                    end
                end
            end
            default: ;
        endcase
        n_ov = emit || (r_ov && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_held  <= '0;
            r_ov    <= 1'b0;
            r_limit <= SIZE_W'(1048576);
            r_max   <= SIZE_W'(16777216);
            r_keep  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_held  <= n_held;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CACHE_LIMIT: r_limit <= i_cfg_data;
                    CFG_MAX_CACHED:  r_max   <= i_cfg_data;
                    CFG_KEEP_RES:    r_keep  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op     <= i_opcode;
            r_req    <= i_request_bytes;
            r_bbase  <= i_block_base;
            r_bbytes <= i_block_bytes;
        end
        r_total    <= n_total;
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_bd       <= n_bd;
        r_sel_base <= n_sel_base;
        r_sel_size <= n_sel_size;
        if (emit) begin
            r_kind   <= n_kind;
            r_obase  <= n_obase;
            r_obytes <= n_obytes;
            r_oold   <= n_oold;
            r_ototal <= n_ototal;
            r_olast  <= n_olast;
        end
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_out_base     = r_obase;
    assign o_out_bytes    = r_obytes;
    assign o_old_bytes    = r_oold;
    assign o_cached_total = r_ototal;
    assign o_last         = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CACHE_ENTRIES))
        else $error("entry count above capacity");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_held == '0)
        else $error("empty list holds bytes");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) && r_kind == K_FLUSH_DONE |-> r_count == '0)
        else $error("flush done with entries left");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> CNT_W'(r_idx) < r_count)
        else $error("scan beyond valid entries");

    a_op_req_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAD |-> r_op == OP_REQUEST)
        else $error("request path entered for another opcode");

endmodule
`default_nettype wire
